>>> sv/rbsf_pkg.sv
package rbsf_pkg;

  localparam int N_ATOMS    = 64;
  localparam int N_BONDS    = 128;
  localparam int N_PARTNERS = 5;

  localparam int ID_W    = 24;
  localparam int AIDX_W  = 6;
  localparam int BIDX_W  = 7;
  localparam int SLOT_W  = 3;
  localparam int ACNT_W  = 7;
  localparam int BCNT_W  = 8;
  localparam int CFGA_W  = 2;
  localparam int CFGD_W  = 8;

  localparam logic [CFGA_W-1:0] CFG_ATOM_COUNT = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_BOND_LIMIT = 2'd1;

  localparam logic [2:0] REQ_LOAD    = 3'd0;
  localparam logic [2:0] REQ_ADD     = 3'd1;
  localparam logic [2:0] REQ_SET_ROT = 3'd2;
  localparam logic [2:0] REQ_SET_ACT = 3'd3;
  localparam logic [2:0] REQ_BUILD   = 3'd4;
  localparam logic [2:0] REQ_DEFIX   = 3'd5;
  localparam logic [2:0] REQ_QUERY   = 3'd6;
  localparam logic [2:0] REQ_READ    = 3'd7;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ATOM_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_SLOTS_FULL   = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
  localparam logic [2:0] ST_BOND_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_ZERO_PARTNER = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_LK_ADDR, S_LK_CMP,
    S_ADD1, S_ADD2, S_FB_ADDR, S_FB_CMP,
    S_BQ1, S_BQ_PC, S_BQ_ADDR, S_BQ_CMP, S_RD_DATA,
    S_DF_K, S_DF_CNT, S_DF_ADDR, S_DF_CMP,
    S_BD_K, S_BD_ENDS, S_BD_LKB, S_BD_PC0, S_BD_P0ADDR, S_BD_P0DATA,
    S_BD_HEAD, S_BD_HEADDATA, S_BD_LKH, S_BD_PC1, S_BD_PADDR, S_BD_PDATA,
    S_BD_MADDR, S_BD_MCMP, S_BD_FIN, S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              bonded;
    logic [ID_W-1:0]   side_atom;
    logic [ACNT_W-1:0] side_count;
    logic              bond_live;
  } rbsf_res_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [ID_W-1:0] atom_id;
    logic [ID_W-1:0] partner_id;
    logic            flag;
    logic [BIDX_W-1:0] bond_index;
    logic [AIDX_W-1:0] position;
  } rbsf_req_t;

endpackage

>>> sv/rbsf_if.sv
interface rbsf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [23:0] atom_id;
  logic [23:0] partner_id;
  logic        flag;
  logic [6:0]  bond_index;
  logic [5:0]  position;
  modport source(output valid, req_type, atom_id, partner_id, flag, bond_index, position,
                 input ready);
  modport sink(input valid, req_type, atom_id, partner_id, flag, bond_index, position,
               output ready);
endinterface

interface rbsf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        bonded;
  logic [23:0] side_atom;
  logic [6:0]  side_count;
  logic        bond_live;
  modport source(output valid, status, bonded, side_atom, side_count, bond_live,
                 input ready);
  modport sink(input valid, status, bonded, side_atom, side_count, bond_live,
               output ready);
endinterface

interface rbsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

>>> sv/rbsf_ram.sv
module rbsf_ram #(
  parameter int AW = 6,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rbsf_seq.sv
module rbsf_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  rbsf_pkg::rbsf_req_t          req,
  input  logic [rbsf_pkg::ACNT_W-1:0]  eff_atoms,
  input  logic [rbsf_pkg::BCNT_W-1:0]  eff_bonds,
  output logic                         idle,
  output logic                         done,
  output rbsf_pkg::rbsf_res_t          res
);
  import rbsf_pkg::*;

  localparam int PT_AW = AIDX_W + SLOT_W;
  localparam int SL_AW = BIDX_W + AIDX_W;

  seq_state_t state_r, state_nxt, ret_r, ret_nxt;
  rbsf_req_t  rq_r, rq_nxt;
  rbsf_res_t  res_r, res_nxt;
  logic [ID_W-1:0]   key_r, key_nxt, a_r, a_nxt, ca_r, ca_nxt;
  logic [ACNT_W-1:0] i_r, i_nxt, cnt_r, cnt_nxt, h_r, h_nxt, m_r, m_nxt;
  logic [ACNT_W-1:0] al_r, al_nxt, n_lk, sc;
  logic [AIDX_W-1:0] idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic [BCNT_W-1:0] k_r, k_nxt, bf_r, bf_nxt;
  logic [SLOT_W-1:0] j_r, j_nxt, pc_r, pc_nxt;
  logic [N_BONDS-1:0] rot_r, rot_nxt, act_r, act_nxt, scv_r, scv_nxt;

  logic              at_we;
  logic [AIDX_W-1:0] at_wa, at_ra;
  logic [ID_W-1:0]   at_wd, at_rd;
  logic              pn_we;
  logic [AIDX_W-1:0] pn_wa, pn_ra;
  logic [SLOT_W-1:0] pn_wd, pn_rd;
  logic              pt_we;
  logic [PT_AW-1:0]  pt_wa, pt_ra;
  logic [ID_W-1:0]   pt_wd, pt_rd;
  logic              be_we;
  logic [BIDX_W-1:0] be_wa, be_ra;
  logic [2*ID_W-1:0] be_wd, be_rd;
  logic              sn_we;
  logic [BIDX_W-1:0] sn_wa, sn_ra;
  logic [ACNT_W-1:0] sn_wd, sn_rd;
  logic              sl_we;
  logic [SL_AW-1:0]  sl_wa, sl_ra;
  logic [ID_W-1:0]   sl_wd, sl_rd;

  rbsf_ram #(.AW(AIDX_W), .DW(ID_W)) u_atoms (
    .clk, .we(at_we), .waddr(at_wa), .wdata(at_wd), .raddr(at_ra), .rdata(at_rd));
  rbsf_ram #(.AW(AIDX_W), .DW(SLOT_W)) u_pcnt (
    .clk, .we(pn_we), .waddr(pn_wa), .wdata(pn_wd), .raddr(pn_ra), .rdata(pn_rd));
  rbsf_ram #(.AW(PT_AW), .DW(ID_W)) u_ptab (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
  rbsf_ram #(.AW(BIDX_W), .DW(2*ID_W)) u_ends (
    .clk, .we(be_we), .waddr(be_wa), .wdata(be_wd), .raddr(be_ra), .rdata(be_rd));
  rbsf_ram #(.AW(BIDX_W), .DW(ACNT_W)) u_scnt (
    .clk, .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
  rbsf_ram #(.AW(SL_AW), .DW(ID_W)) u_side (
    .clk, .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd));

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;
  assign n_lk = (al_r < eff_atoms) ? al_r : eff_atoms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      al_r    <= '0;
      bf_r    <= '0;
      rot_r   <= '0;
      act_r   <= '0;
      scv_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      al_r    <= al_nxt;
      bf_r    <= bf_nxt;
      rot_r   <= rot_nxt;
      act_r   <= act_nxt;
      scv_r   <= scv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rq_r    <= rq_nxt;
    res_r   <= res_nxt;
    key_r   <= key_nxt;
    a_r     <= a_nxt;
    ca_r    <= ca_nxt;
    i_r     <= i_nxt;
    cnt_r   <= cnt_nxt;
    h_r     <= h_nxt;
    m_r     <= m_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    pc_r    <= pc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rq_nxt    = rq_r;
    res_nxt   = res_r;
    key_nxt   = key_r;
    a_nxt     = a_r;
    ca_nxt    = ca_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    h_nxt     = h_r;
    m_nxt     = m_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    pc_nxt    = pc_r;
    al_nxt    = al_r;
    bf_nxt    = bf_r;
    rot_nxt   = rot_r;
    act_nxt   = act_r;
    scv_nxt   = scv_r;
    sc        = '0;
    at_we = 1'b0; at_wa = al_r[AIDX_W-1:0]; at_wd = rq_r.atom_id; at_ra = i_r[AIDX_W-1:0];
    pn_we = 1'b0; pn_wa = idx_r; pn_wd = '0; pn_ra = idx_r;
    pt_we = 1'b0; pt_wa = {idx_r, j_r}; pt_wd = rq_r.partner_id; pt_ra = {idx_r, j_r};
    be_we = 1'b0; be_wa = bf_r[BIDX_W-1:0]; be_wd = {rq_r.atom_id, rq_r.partner_id};
    be_ra = k_r[BIDX_W-1:0];
    sn_we = 1'b0; sn_wa = k_r[BIDX_W-1:0]; sn_wd = cnt_r; sn_ra = k_r[BIDX_W-1:0];
    sl_we = 1'b0; sl_wa = {k_r[BIDX_W-1:0], cnt_r[AIDX_W-1:0]}; sl_wd = ca_r;
    sl_ra = {k_r[BIDX_W-1:0], m_r[AIDX_W-1:0]};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          rq_nxt    = req;
          res_nxt   = '0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        k_nxt = '0;
        i_nxt = '0;
        key_nxt = rq_r.atom_id;
        case (rq_r.req_type)
          REQ_LOAD: begin
            if (al_r < eff_atoms) begin
              at_we  = 1'b1;
              pn_we  = 1'b1;
              pn_wa  = al_r[AIDX_W-1:0];
              al_nxt = al_r + 1'b1;
            end
            state_nxt = S_DONE;
          end
          REQ_ADD: begin
            ret_nxt = S_ADD1;
            state_nxt = S_LK_ADDR;
          end
          REQ_SET_ROT, REQ_SET_ACT: state_nxt = S_FB_ADDR;
          REQ_BUILD: state_nxt = S_BD_K;
          REQ_DEFIX: state_nxt = S_DF_K;
          REQ_QUERY: begin
            ret_nxt = S_BQ1;
            state_nxt = S_LK_ADDR;
          end
          default: begin
            if ({1'b0, rq_r.bond_index} >= bf_r) begin
              res_nxt.status = ST_BOND_UNKNOWN;
              state_nxt = S_DONE;
            end else begin
              sn_ra = rq_r.bond_index;
              sl_ra = {rq_r.bond_index, rq_r.position};
              state_nxt = S_RD_DATA;
            end
          end
        endcase
      end
      S_LK_ADDR: begin
        if (i_r >= n_lk) begin
          found_nxt = 1'b0;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (at_rd == key_r) begin
          found_nxt = 1'b1;
          idx_nxt   = i_r[AIDX_W-1:0];
          state_nxt = ret_r;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_LK_ADDR;
        end
      end
      S_ADD1: begin
        if (!found_r) begin
          res_nxt.status = ST_ATOM_UNKNOWN;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ADD2;
        end
      end
      S_ADD2: begin
        state_nxt = S_DONE;
        if (pn_rd >= SLOT_W'(N_PARTNERS)) begin
          res_nxt.status = ST_SLOTS_FULL;
        end else begin
          pt_we = 1'b1;
          pt_wa = {idx_r, pn_rd};
          pn_we = 1'b1;
          pn_wd = pn_rd + 1'b1;
          if (bf_r >= eff_bonds) begin
            res_nxt.status = ST_TABLE_FULL;
          end else begin
            be_we = 1'b1;
            rot_nxt[bf_r[BIDX_W-1:0]] = 1'b1;
            act_nxt[bf_r[BIDX_W-1:0]] = 1'b1;
            bf_nxt = bf_r + 1'b1;
            if (rq_r.partner_id == '0) begin
              res_nxt.status = ST_ZERO_PARTNER;
            end
          end
        end
      end
      S_FB_ADDR: begin
        if (k_r >= bf_r) begin
          res_nxt.status = ST_BOND_UNKNOWN;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FB_CMP;
        end
      end
      S_FB_CMP: begin
        if (be_rd == {rq_r.atom_id, rq_r.partner_id}) begin
          if (rq_r.req_type == REQ_SET_ROT) begin
            rot_nxt[k_r[BIDX_W-1:0]] = rq_r.flag;
          end else begin
            act_nxt[k_r[BIDX_W-1:0]] = rq_r.flag;
          end
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_FB_ADDR;
        end
      end
      S_BQ1: begin
        if (!found_r) begin
          res_nxt.status = ST_ATOM_UNKNOWN;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BQ_PC;
        end
      end
      S_BQ_PC: begin
        pc_nxt = pn_rd;
        j_nxt  = '0;
        state_nxt = S_BQ_ADDR;
      end
      S_BQ_ADDR: begin
        state_nxt = (j_r >= pc_r) ? S_DONE : S_BQ_CMP;
      end
      S_BQ_CMP: begin
        if (pt_rd == rq_r.partner_id) begin
          res_nxt.bonded = 1'b1;
          state_nxt = S_DONE;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_BQ_ADDR;
        end
      end
      S_RD_DATA: begin
        sc = scv_r[rq_r.bond_index] ? sn_rd : '0;
        res_nxt.side_count = sc;
        res_nxt.side_atom  = ({1'b0, rq_r.position} < sc) ? sl_rd : '0;
        res_nxt.bond_live  = act_r[rq_r.bond_index] && (sc != '0);
        state_nxt = S_DONE;
      end
      S_DF_K: begin
        state_nxt = (k_r >= bf_r) ? S_DONE : S_DF_CNT;
      end
      S_DF_CNT: begin
        cnt_nxt = scv_r[k_r[BIDX_W-1:0]] ? sn_rd : '0;
        m_nxt   = '0;
        state_nxt = S_DF_ADDR;
      end
      S_DF_ADDR: begin
        if (m_r >= cnt_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_DF_K;
        end else begin
          state_nxt = S_DF_CMP;
        end
      end
      S_DF_CMP: begin
        if (sl_rd == rq_r.atom_id) begin
          act_nxt[k_r[BIDX_W-1:0]] = 1'b0;
          rot_nxt[k_r[BIDX_W-1:0]] = 1'b0;
          k_nxt = k_r + 1'b1;
          state_nxt = S_DF_K;
        end else begin
          m_nxt = m_r + 1'b1;
          state_nxt = S_DF_ADDR;
        end
      end
      S_BD_K: begin
        cnt_nxt = '0;
        if (k_r[BIDX_W]) begin
          state_nxt = S_DONE;
        end else if (k_r < bf_r && rot_r[k_r[BIDX_W-1:0]]) begin
          state_nxt = S_BD_ENDS;
        end else begin
          sn_we = 1'b1;
          sn_wd = '0;
          scv_nxt[k_r[BIDX_W-1:0]] = 1'b1;
          k_nxt = k_r + 1'b1;
        end
      end
      S_BD_ENDS: begin
        a_nxt   = be_rd[2*ID_W-1:ID_W];
        key_nxt = be_rd[ID_W-1:0];
        i_nxt   = '0;
        ret_nxt = S_BD_LKB;
        state_nxt = S_LK_ADDR;
      end
      S_BD_LKB: begin
        state_nxt = found_r ? S_BD_PC0 : S_BD_FIN;
      end
      S_BD_PC0: begin
        pc_nxt = pn_rd;
        j_nxt  = '0;
        state_nxt = S_BD_P0ADDR;
      end
      S_BD_P0ADDR: begin
        if (j_r >= pc_r) begin
          h_nxt = '0;
          state_nxt = S_BD_HEAD;
        end else begin
          state_nxt = S_BD_P0DATA;
        end
      end
      S_BD_P0DATA: begin
        if (pt_rd != a_r && !cnt_r[AIDX_W]) begin
          sl_we = 1'b1;
          sl_wd = pt_rd;
          cnt_nxt = cnt_r + 1'b1;
        end
        j_nxt = j_r + 1'b1;
        state_nxt = S_BD_P0ADDR;
      end
      S_BD_HEAD: begin
        sl_ra = {k_r[BIDX_W-1:0], h_r[AIDX_W-1:0]};
        state_nxt = (h_r >= cnt_r) ? S_BD_FIN : S_BD_HEADDATA;
      end
      S_BD_HEADDATA: begin
        key_nxt = sl_rd;
        i_nxt   = '0;
        ret_nxt = S_BD_LKH;
        state_nxt = S_LK_ADDR;
      end
      S_BD_LKH: begin
        if (!found_r) begin
          h_nxt = h_r + 1'b1;
          state_nxt = S_BD_HEAD;
        end else begin
          state_nxt = S_BD_PC1;
        end
      end
      S_BD_PC1: begin
        pc_nxt = pn_rd;
        j_nxt  = '0;
        state_nxt = S_BD_PADDR;
      end
      S_BD_PADDR: begin
        if (j_r >= pc_r) begin
          h_nxt = h_r + 1'b1;
          state_nxt = S_BD_HEAD;
        end else begin
          state_nxt = S_BD_PDATA;
        end
      end
      S_BD_PDATA: begin
        ca_nxt = pt_rd;
        m_nxt  = '0;
        if (pt_rd == a_r) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_BD_PADDR;
        end else begin
          state_nxt = S_BD_MADDR;
        end
      end
      S_BD_MADDR: begin
        if (m_r >= cnt_r) begin
          if (!cnt_r[AIDX_W]) begin
            sl_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          j_nxt = j_r + 1'b1;
          state_nxt = S_BD_PADDR;
        end else begin
          state_nxt = S_BD_MCMP;
        end
      end
      S_BD_MCMP: begin
        if (sl_rd == ca_r) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_BD_PADDR;
        end else begin
          m_nxt = m_r + 1'b1;
          state_nxt = S_BD_MADDR;
        end
      end
      S_BD_FIN: begin
        sn_we = 1'b1;
        sn_wd = cnt_r;
        scv_nxt[k_r[BIDX_W-1:0]] = 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = S_BD_K;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rotatable_bond_side_finder.sv
// Channel   Dir  Payload                                                   Transfer
// in_ch     in   req_type, atom_id, partner_id, flag, bond_index, position valid & ready
// out_ch    out  status, bonded, side_atom, side_count, bond_live          valid & ready
// cfg_ch    in   addr (0 atom_count, 1 bond_limit), data                   valid & ready
//
// One request is in flight at a time; in_ch is ready only when the sequencer is idle
// and the result register is empty. A load passes through the dispatch and done states
// before its result is registered; lookups search the atom slots one at a time through the
// single atom id memory port, with an address and a compare state per slot. A build walks
// every bond, atom and right-side entry one memory read at a time. Reset is synchronous
// and clears counters, flags and the result register. A stalled out_ch holds its result
// and blocks the next input transfer.
module rotatable_bond_side_finder (
  input  logic       clk,
  input  logic       rst_n,
  rbsf_in_if.sink    in_ch,
  rbsf_out_if.source out_ch,
  rbsf_cfg_if.sink   cfg_ch
);
  import rbsf_pkg::*;

  logic [ACNT_W-1:0] atom_count_r, eff_atoms;
  logic [BCNT_W-1:0] bond_limit_r, eff_bonds;
  logic              out_vld_r, out_vld_nxt;
  rbsf_res_t         out_r, seq_res;
  rbsf_req_t         req;
  logic              seq_idle, seq_done, start;

  assign cfg_ch.ready = 1'b1;
  assign eff_atoms = (atom_count_r > ACNT_W'(N_ATOMS)) ? ACNT_W'(N_ATOMS) : atom_count_r;
  assign eff_bonds = (bond_limit_r > BCNT_W'(N_BONDS)) ? BCNT_W'(N_BONDS) : bond_limit_r;

  assign in_ch.ready = seq_idle && !out_vld_r;
  assign start = in_ch.valid && in_ch.ready;
  assign req = '{req_type: in_ch.req_type, atom_id: in_ch.atom_id,
                 partner_id: in_ch.partner_id, flag: in_ch.flag,
                 bond_index: in_ch.bond_index, position: in_ch.position};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r <= '0;
      bond_limit_r <= BCNT_W'(N_BONDS);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_ATOM_COUNT: atom_count_r <= cfg_ch.data[ACNT_W-1:0];
        CFG_BOND_LIMIT: bond_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (seq_done) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      out_r     <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (seq_done) begin
        out_r <= seq_res;
      end
    end
  end

  rbsf_seq u_seq (
    .clk, .rst_n, .start, .req, .eff_atoms, .eff_bonds,
    .idle(seq_idle), .done(seq_done), .res(seq_res));

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_r.status;
  assign out_ch.bonded     = out_r.bonded;
  assign out_ch.side_atom  = out_r.side_atom;
  assign out_ch.side_count = out_r.side_count;
  assign out_ch.bond_live  = out_r.bond_live;

endmodule

>>> sv/rbsf_chk.sv
module rbsf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        bonded,
  input logic [6:0]  side_count
);
  import rbsf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("input transfer while a result is pending");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result appeared one cycle after input transfer");

  a_bonded_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bonded |-> status == ST_OK)
    else $error("bonded flag with error status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> side_count <= 7'(N_ATOMS))
    else $error("side count out of range");

endmodule

bind rotatable_bond_side_finder rbsf_chk u_rbsf_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .bonded(out_ch.bonded), .side_count(out_ch.side_count));
